[sv/sll_pkg.sv]
`timescale 1ns / 1ps
// shared types, field widths and codes for the linked list engine
package sll_pkg;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 8;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int FND_W  = 8;
    localparam int LEN_W  = 8;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_STATUS,
        OP_FREE_RD,
        OP_ALLOC,
        OP_ALLOC_HEAD,
        OP_PRIME,
        OP_ADV,
        OP_FOUND,
        OP_GET_CAP,
        OP_INS_LINK,
        OP_INS_PREV,
        OP_DEL_UNLINK,
        OP_DEL_RELINK,
        OP_CLEAR,
        OP_OUT_LOAD
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [STAT_W-1:0] stat;
    } t_dp_ctl;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             pos_zero;
        logic             pos_one;
        logic             pos_gt_cnt;
        logic             pos_gt_cnt1;
        logic             cnt_zero;
        logic             free_zero;
        logic             k_eq_pos;
        logic             k_eq_posm1;
        logic             k_gt_cnt;
        logic             elem_match;
        logic             out_busy;
    } t_dp_sts;

endpackage

[sv/sll_intf.sv]
`timescale 1ns / 1ps
// command and response channel interfaces
interface sll_cmd_if;
    import sll_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;

    modport source (output valid, command, position, value, input ready);
    modport sink (input valid, command, position, value, output ready);
endinterface

interface sll_rsp_if;
    import sll_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  value_out;
    logic [FND_W-1:0]  found_position;
    logic [LEN_W-1:0]  length;

    modport source (output valid, status, value_out, found_position, length, input ready);
    modport sink (input valid, status, value_out, found_position, length, output ready);
endinterface

[sv/sll_dp.sv]
`timescale 1ns / 1ps
// datapath: link and element memories, list pointers, walk registers, response register
module sll_dp #(
    parameter int POOL_SLOTS    = 256,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sll_pkg::t_dp_ctl             i_ctl,
    output sll_pkg::t_dp_sts             o_sts,
    input  logic [sll_pkg::CMD_W-1:0]    i_command,
    input  logic [sll_pkg::POS_W-1:0]    i_position,
    input  logic [sll_pkg::VAL_W-1:0]    i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [sll_pkg::STAT_W-1:0]   o_status,
    output logic [sll_pkg::VAL_W-1:0]    o_value_out,
    output logic [sll_pkg::FND_W-1:0]    o_found_position,
    output logic [sll_pkg::LEN_W-1:0]    o_length
);
    import sll_pkg::*;

    localparam int PTR_W      = $clog2(POOL_SLOTS);
    localparam int EW         = ELEMENT_WIDTH;
    localparam int CAP        = POOL_SLOTS - 2;
    localparam int LAST_CHAIN = POOL_SLOTS - 3;
    localparam int CW         = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;

    // slots at or above the high-water mark still hold their reset chain link
    function automatic logic [PTR_W-1:0] implied_link(input logic [PTR_W-1:0] a);
        logic [PTR_W-1:0] res;
        res = '0;
        if (a != '0 && a <= PTR_W'(LAST_CHAIN)) begin
            res = a + 1'b1;
        end
        return res;
    endfunction

    logic [PTR_W-1:0] link_mem [POOL_SLOTS];
    logic [EW-1:0]    elem_mem [POOL_SLOTS];

    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [EW-1:0]     r_val, n_val;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_free, n_free;
    logic [PTR_W-1:0]  r_mark, n_mark;
    logic [PTR_W-1:0]  r_count, n_count;
    logic [PTR_W-1:0]  r_cur, n_cur;
    logic [PTR_W-1:0]  r_prev, n_prev;
    logic [PTR_W-1:0]  r_new, n_new;
    logic [PTR_W-1:0]  r_k, n_k;
    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic [VAL_W-1:0]  r_res_vout, n_res_vout;
    logic [FND_W-1:0]  r_res_found, n_res_found;
    logic              r_o_valid, n_o_valid;
    logic [STAT_W-1:0] r_o_status, n_o_status;
    logic [VAL_W-1:0]  r_o_vout, n_o_vout;
    logic [FND_W-1:0]  r_o_found, n_o_found;
    logic [LEN_W-1:0]  r_o_len, n_o_len;

    logic [PTR_W-1:0]  r_q_link;
    logic [PTR_W-1:0]  r_q_addr;
    logic              r_q_fresh;
    logic [EW-1:0]     r_q_elem;

    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
    logic              lk_we;
    logic [PTR_W-1:0]  lk_waddr;
    logic [PTR_W-1:0]  lk_wdata;
    logic              el_we;
    logic [PTR_W-1:0]  lnk;

    logic [CW-1:0]     pos_ext, cnt_ext, k_ext;

    assign lnk     = r_q_fresh ? implied_link(r_q_addr) : r_q_link;
    assign pos_ext = CW'(r_pos);
    assign cnt_ext = CW'(r_count);
    assign k_ext   = CW'(r_k);

    always_comb begin
        o_sts.cmd         = r_cmd;
        o_sts.pos_zero    = (r_pos == '0);
        o_sts.pos_one     = (r_pos == POS_W'(1));
        o_sts.pos_gt_cnt  = (pos_ext > cnt_ext);
        o_sts.pos_gt_cnt1 = (pos_ext > cnt_ext + CW'(1));
        o_sts.cnt_zero    = (r_count == '0);
        o_sts.free_zero   = (r_free == '0);
        o_sts.k_eq_pos    = (k_ext == pos_ext);
        o_sts.k_eq_posm1  = (k_ext + CW'(1) == pos_ext);
        o_sts.k_gt_cnt    = (k_ext > cnt_ext);
        o_sts.elem_match  = (r_q_elem == r_val);
        o_sts.out_busy    = r_o_valid & ~i_ready;
    end

    always_comb begin
        n_cmd        = r_cmd;
        n_pos        = r_pos;
        n_val        = r_val;
        n_head       = r_head;
        n_free       = r_free;
        n_mark       = r_mark;
        n_count      = r_count;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_new        = r_new;
        n_k          = r_k;
        n_res_status = r_res_status;
        n_res_vout   = r_res_vout;
        n_res_found  = r_res_found;
        n_o_valid    = r_o_valid & ~i_ready;
        n_o_status   = r_o_status;
        n_o_vout     = r_o_vout;
        n_o_found    = r_o_found;
        n_o_len      = r_o_len;
        rd_en        = 1'b0;
        rd_addr      = r_head;
        lk_we        = 1'b0;
        lk_waddr     = r_cur;
        lk_wdata     = r_free;
        el_we        = 1'b0;
        case (i_ctl.op)
            OP_NONE: begin
            end
            OP_LATCH: begin
                n_cmd        = i_command;
                n_pos        = i_position;
                n_val        = EW'(i_value);
                n_res_status = ST_OK;
                n_res_vout   = '0;
                n_res_found  = '0;
            end
            OP_STATUS: begin
                n_res_status = i_ctl.stat;
            end
            OP_FREE_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_free;
            end
            OP_ALLOC: begin
                el_we   = 1'b1;
                n_new   = r_free;
                n_free  = lnk;
                n_count = r_count + 1'b1;
                if (r_q_fresh) begin
                    n_mark = r_mark + 1'b1;
                end
            end
            OP_ALLOC_HEAD: begin
                el_we    = 1'b1;
                lk_we    = 1'b1;
                lk_waddr = r_free;
                lk_wdata = r_head;
                n_head   = r_free;
                n_free   = lnk;
                n_count  = r_count + 1'b1;
                if (r_q_fresh) begin
                    n_mark = r_mark + 1'b1;
                end
            end
            OP_PRIME: begin
                rd_en   = 1'b1;
                rd_addr = r_head;
                n_cur   = r_head;
                n_k     = PTR_W'(1);
            end
            OP_ADV: begin
                rd_en   = 1'b1;
                rd_addr = lnk;
                n_prev  = r_cur;
                n_cur   = lnk;
                n_k     = r_k + 1'b1;
            end
            OP_FOUND: begin
                n_res_found = FND_W'(r_k);
            end
            OP_GET_CAP: begin
                n_res_vout = VAL_W'(r_q_elem);
            end
            OP_INS_LINK: begin
                lk_we    = 1'b1;
                lk_waddr = r_new;
                lk_wdata = lnk;
            end
            OP_INS_PREV: begin
                lk_we    = 1'b1;
                lk_waddr = r_cur;
                lk_wdata = r_new;
            end
            OP_DEL_UNLINK: begin
                // victim goes to the front of the free chain
                n_res_vout = VAL_W'(r_q_elem);
                n_count    = r_count - 1'b1;
                n_free     = r_cur;
                lk_we      = 1'b1;
                lk_waddr   = r_cur;
                lk_wdata   = r_free;
                if (r_pos == POS_W'(1)) begin
                    n_head = lnk;
                end
            end
            OP_DEL_RELINK: begin
                lk_we    = 1'b1;
                lk_waddr = r_prev;
                lk_wdata = lnk;
            end
            OP_CLEAR: begin
                n_head  = '0;
                n_free  = PTR_W'(1);
                n_mark  = PTR_W'(1);
                n_count = '0;
            end
            OP_OUT_LOAD: begin
                n_o_valid  = 1'b1;
                n_o_status = r_res_status;
                n_o_vout   = r_res_vout;
                n_o_found  = r_res_found;
                n_o_len    = LEN_W'(r_count);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_free    <= PTR_W'(1);
            r_mark    <= PTR_W'(1);
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_free    <= n_free;
            r_mark    <= n_mark;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_new        <= n_new;
        r_k          <= n_k;
        r_res_status <= n_res_status;
        r_res_vout   <= n_res_vout;
        r_res_found  <= n_res_found;
        r_o_status   <= n_o_status;
        r_o_vout     <= n_o_vout;
        r_o_found    <= n_o_found;
        r_o_len      <= n_o_len;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_q_link  <= link_mem[rd_addr];
            r_q_elem  <= elem_mem[rd_addr];
            r_q_addr  <= rd_addr;
            r_q_fresh <= (rd_addr >= r_mark);
        end
    end

    always_ff @(posedge i_clk) begin
        if (lk_we) begin
            link_mem[lk_waddr] <= lk_wdata;
        end
        if (el_we) begin
            elem_mem[r_free] <= r_val;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_value_out      = r_o_vout;
    assign o_found_position = r_o_found;
    assign o_length         = r_o_len;

`ifndef NO_ASSERTIONS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= PTR_W'(CAP))
        else $error("element count above pool capacity");

    a_free_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free == '0) == (r_count == PTR_W'(CAP)))
        else $error("free chain end disagrees with element count");

    a_head_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == '0) == (r_count == '0))
        else $error("list head disagrees with element count");

    a_mark_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < r_mark)
        else $error("more elements than slots ever handed out");
`endif

endmodule

[sv/sll_ctrl.sv]
`timescale 1ns / 1ps
// controller state machine: sequences checks, walks and link updates per command
module sll_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  sll_pkg::t_dp_sts  i_sts,
    output sll_pkg::t_dp_ctl  o_ctl
);
    import sll_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_ALLOC  = 3'd2;
    localparam logic [2:0] S_PRIME  = 3'd3;
    localparam logic [2:0] S_WALK   = 3'd4;
    localparam logic [2:0] S_INS_B  = 3'd5;
    localparam logic [2:0] S_DEL_B  = 3'd6;
    localparam logic [2:0] S_RESP   = 3'd7;

    logic [2:0] r_state, n_state;
    t_dp_ctl    ctl;

    always_comb begin
        n_state  = r_state;
        ctl.op   = OP_NONE;
        ctl.stat = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    ctl.op  = OP_LATCH;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.cmd)
                    CMD_INSERT: begin
                        if (i_sts.pos_zero || i_sts.pos_gt_cnt1) begin
                            ctl.op   = OP_STATUS;
                            ctl.stat = ST_BAD_POS;
                            n_state  = S_RESP;
                        end else if (i_sts.free_zero) begin
                            ctl.op   = OP_STATUS;
                            ctl.stat = ST_FULL;
                            n_state  = S_RESP;
                        end else begin
                            ctl.op  = OP_FREE_RD;
                            n_state = S_ALLOC;
                        end
                    end
                    CMD_DELETE, CMD_GET: begin
                        if (i_sts.cnt_zero) begin
                            ctl.op   = OP_STATUS;
                            ctl.stat = ST_EMPTY;
                            n_state  = S_RESP;
                        end else if (i_sts.pos_zero || i_sts.pos_gt_cnt) begin
                            ctl.op   = OP_STATUS;
                            ctl.stat = ST_BAD_POS;
                            n_state  = S_RESP;
                        end else begin
                            n_state = S_PRIME;
                        end
                    end
                    CMD_LOCATE: begin
                        n_state = S_PRIME;
                    end
                    CMD_CLEAR: begin
                        ctl.op  = OP_CLEAR;
                        n_state = S_RESP;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_ALLOC: begin
                if (i_sts.pos_one) begin
                    ctl.op  = OP_ALLOC_HEAD;
                    n_state = S_RESP;
                end else begin
                    ctl.op  = OP_ALLOC;
                    n_state = S_PRIME;
                end
            end
            S_PRIME: begin
                ctl.op  = OP_PRIME;
                n_state = S_WALK;
            end
            S_WALK: begin
                case (i_sts.cmd)
                    CMD_INSERT: begin
                        // stop on the slot before the insertion point
                        if (i_sts.k_eq_posm1) begin
                            ctl.op  = OP_INS_LINK;
                            n_state = S_INS_B;
                        end else begin
                            ctl.op = OP_ADV;
                        end
                    end
                    CMD_DELETE: begin
                        if (i_sts.k_eq_pos) begin
                            ctl.op  = OP_DEL_UNLINK;
                            n_state = i_sts.pos_one ? S_RESP : S_DEL_B;
                        end else begin
                            ctl.op = OP_ADV;
                        end
                    end
                    CMD_GET: begin
                        if (i_sts.k_eq_pos) begin
                            ctl.op  = OP_GET_CAP;
                            n_state = S_RESP;
                        end else begin
                            ctl.op = OP_ADV;
                        end
                    end
                    CMD_LOCATE: begin
                        if (i_sts.k_gt_cnt) begin
                            n_state = S_RESP;
                        end else if (i_sts.elem_match) begin
                            ctl.op  = OP_FOUND;
                            n_state = S_RESP;
                        end else begin
                            ctl.op = OP_ADV;
                        end
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_INS_B: begin
                ctl.op  = OP_INS_PREV;
                n_state = S_RESP;
            end
            S_DEL_B: begin
                ctl.op  = OP_DEL_RELINK;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!i_sts.out_busy) begin
                    ctl.op  = OP_OUT_LOAD;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_ctl       = ctl;

endmodule

[sv/static_linked_list_engine.sv]
`timescale 1ns / 1ps
// top level of the array-backed linked list engine with free list
//
//   channel  role    word fields
//   i_cmd    sink    command, position, value
//   o_rsp    source  status, value_out, found_position, length
//
// the list walk follows one link per cycle through the registered link memory read
// reset is synchronous; slots never handed out read their reset link from a
// high-water mark, so neither reset nor clear needs a pass over the pool
// a finished word sits in the output register while the next command is taken;
// a command waits in its response state as long as that word is still unread
module static_linked_list_engine #(
    parameter int POOL_SLOTS    = 256,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sll_cmd_if.sink    i_cmd,
    sll_rsp_if.source  o_rsp
);
    import sll_pkg::*;

    t_dp_ctl ctl;
    t_dp_sts sts;
    logic    cmd_ready;

    sll_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (cmd_ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    sll_dp #(
        .POOL_SLOTS    (POOL_SLOTS),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_sts            (sts),
        .i_command        (i_cmd.command),
        .i_position       (i_cmd.position),
        .i_value          (i_cmd.value),
        .o_valid          (o_rsp.valid),
        .i_ready          (o_rsp.ready),
        .o_status         (o_rsp.status),
        .o_value_out      (o_rsp.value_out),
        .o_found_position (o_rsp.found_position),
        .o_length         (o_rsp.length)
    );

    assign i_cmd.ready = cmd_ready;

endmodule
